[sv/tft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_pkg
// Shared types, widths and reset values for the thermal frequency throttle.
// ----------------------------------------------------------------------------
package tft_pkg;

    localparam int TEMP_W  = 9;
    localparam int TIME_W  = 48;
    localparam int FREQ_W  = 24;
    localparam int THR_W   = 7;
    localparam int HYST_W  = 5;
    localparam int HOLD_W  = 24;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;
    // signed compare width: covers threshold + 16 and threshold - hysteresis
    localparam int CMP_W   = 11;

    localparam logic [THR_W-1:0]  BASE_TEMP_RST  = THR_W'(70);
    localparam logic [FREQ_W-1:0] CRIT_RST       = FREQ_W'(960000);
    localparam logic [FREQ_W-1:0] SEVERE_RST     = FREQ_W'(1267200);
    localparam logic [FREQ_W-1:0] HIGH_RST       = FREQ_W'(1728000);
    localparam logic [FREQ_W-1:0] MILD_RST       = FREQ_W'(2265600);
    localparam logic [HYST_W-1:0] HYST_RST       = HYST_W'(5);
    localparam logic [HOLD_W-1:0] HOLD_RST       = HOLD_W'(1000000);
    localparam logic [FREQ_W-1:0] FREQ_UNLIMITED = {FREQ_W{1'b1}};

    localparam logic [CMP_W-1:0] BAND_CRIT   = CMP_W'(1 << 4);
    localparam logic [CMP_W-1:0] BAND_SEVERE = CMP_W'(1 << 3);
    localparam logic [CMP_W-1:0] BAND_HIGH   = CMP_W'(1 << 2);

    typedef enum logic [CIDX_W-1:0] {
        REG_BASE_TEMP        = 3'd0,
        REG_CAP_CRIT         = 3'd1,
        REG_CAP_SEVERE       = 3'd2,
        REG_CAP_HIGH         = 3'd3,
        REG_CAP_MILD         = 3'd4,
        REG_HYSTERESIS       = 3'd5,
        REG_MIN_HOLD         = 3'd6,
        REG_UNTHROTTLED_FREQ = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  base_temp;
        logic [FREQ_W-1:0] cap_crit;
        logic [FREQ_W-1:0] cap_severe;
        logic [FREQ_W-1:0] cap_high;
        logic [FREQ_W-1:0] cap_mild;
        logic [HYST_W-1:0] hysteresis;
        logic [HOLD_W-1:0] min_hold;
        logic [FREQ_W-1:0] unthrottled_freq;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] cap;
        logic              changed;
        logic              throttling;
    } result_t;

endpackage

[sv/tft_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module tft_cfg_regs
    import tft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_BASE_TEMP:        cfg_next.base_temp        = cfg_data[THR_W-1:0];
                REG_CAP_CRIT:         cfg_next.cap_crit         = cfg_data[FREQ_W-1:0];
                REG_CAP_SEVERE:       cfg_next.cap_severe       = cfg_data[FREQ_W-1:0];
                REG_CAP_HIGH:         cfg_next.cap_high         = cfg_data[FREQ_W-1:0];
                REG_CAP_MILD:         cfg_next.cap_mild         = cfg_data[FREQ_W-1:0];
                REG_HYSTERESIS:       cfg_next.hysteresis       = cfg_data[HYST_W-1:0];
                REG_MIN_HOLD:         cfg_next.min_hold         = cfg_data[HOLD_W-1:0];
                REG_UNTHROTTLED_FREQ: cfg_next.unthrottled_freq = cfg_data[FREQ_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_temp        <= BASE_TEMP_RST;
            cfg_reg.cap_crit         <= CRIT_RST;
            cfg_reg.cap_severe       <= SEVERE_RST;
            cfg_reg.cap_high         <= HIGH_RST;
            cfg_reg.cap_mild         <= MILD_RST;
            cfg_reg.hysteresis       <= HYST_RST;
            cfg_reg.min_hold         <= HOLD_RST;
            cfg_reg.unthrottled_freq <= FREQ_UNLIMITED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tft_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_core
// Throttle state and per-sample decision: release with hold time, band select.
// ----------------------------------------------------------------------------
module tft_core
    import tft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [TEMP_W-1:0] temperature,
    input  logic [TIME_W-1:0] now_us,
    input  cfg_t              cfg,
    output result_t           res
);

    logic              throttle_reg;
    logic              throttle_next;
    logic [FREQ_W-1:0] cap_reg;
    logic [FREQ_W-1:0] cap_next;
    logic [TIME_W-1:0] last_change_reg;
    logic [TIME_W-1:0] last_change_next;

    logic signed [CMP_W-1:0] temp_s;
    logic signed [CMP_W-1:0] thr_s;
    logic signed [CMP_W-1:0] release_s;
    logic                    in_release;
    logic                    hold_done;
    logic [TIME_W:0]         hold_end;
    logic [FREQ_W-1:0]       band_freq;
    logic [FREQ_W-1:0]       target;
    logic                    apply;

    always_comb
    begin
        temp_s    = signed'({{(CMP_W-TEMP_W){temperature[TEMP_W-1]}}, temperature});
        thr_s     = signed'({{(CMP_W-THR_W){1'b0}}, cfg.base_temp});
        release_s = thr_s - signed'({{(CMP_W-HYST_W){1'b0}}, cfg.hysteresis});
        in_release = throttle_reg && (temp_s < release_s);
        // hold end is computed one bit wider so it never wraps
        hold_end  = {1'b0, last_change_reg} + {{(TIME_W+1-HOLD_W){1'b0}}, cfg.min_hold};
        hold_done = {1'b0, now_us} >= hold_end;

        if (temp_s >= thr_s + signed'(BAND_CRIT))
            band_freq = cfg.cap_crit;
        else if (temp_s >= thr_s + signed'(BAND_SEVERE))
            band_freq = cfg.cap_severe;
        else if (temp_s >= thr_s + signed'(BAND_HIGH))
            band_freq = cfg.cap_high;
        else if (temp_s > thr_s)
            band_freq = cfg.cap_mild;
        else
            band_freq = '0;

        throttle_next = throttle_reg;
        target        = cap_reg;
        apply         = 1'b0;
        if (in_release)
        begin
            if (hold_done)
            begin
                target        = cfg.unthrottled_freq;
                apply         = 1'b1;
                throttle_next = 1'b0;
            end
        end
        else if (band_freq != '0)
        begin
            target        = band_freq;
            apply         = 1'b1;
            throttle_next = 1'b1;
        end

        res.changed    = apply && (target != cap_reg);
        cap_next       = res.changed ? target : cap_reg;
        last_change_next = res.changed ? now_us : last_change_reg;
        res.cap        = cap_next;
        res.throttling = throttle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_reg    <= 1'b0;
            cap_reg         <= FREQ_UNLIMITED;
            last_change_reg <= '0;
        end
        else if (step)
        begin
            throttle_reg    <= throttle_next;
            cap_reg         <= cap_next;
            last_change_reg <= last_change_next;
        end
    end

    a_change_differs: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.changed |-> res.cap != cap_reg)
        else $error("cap change reported without a new cap");

    a_change_time: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.changed |=> last_change_reg == $past(now_us))
        else $error("change time not taken from the sample");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(cap_reg) && $stable(throttle_reg) && $stable(last_change_reg))
        else $error("throttle state moved without a sample");

    a_nochange_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !res.changed |=> $stable(cap_reg) && $stable(last_change_reg))
        else $error("cap moved on a sample that reported no change");

endmodule

[sv/thermal_frequency_throttle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_frequency_throttle
// Temperature-driven frequency cap with band selection and release hysteresis.
// ----------------------------------------------------------------------------
// One sample can be taken every clock cycle while no output stall holds the
// flow. A sample moves from the input register to the result register at the
// first edge after its input transfer at which the result register is free
// or being emptied; its result is then shown on the outputs from the result
// register until it is taken. The rate is set by the throttle state
// (cap, flag, change time), which is updated in the same cycle the sample
// leaves the input register, so a sample always sees the state left by the
// one before it. A stalled result holds the input register: one more sample
// can enter while it waits, then the input stalls until the result goes out.
// Configuration writes are always ready and must only be issued while no
// sample is in flight.
module thermal_frequency_throttle
    import tft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TEMP_W-1:0]  temperature,
    input  logic [TIME_W-1:0]  now_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FREQ_W-1:0]  cap_freq,
    output logic               cap_changed,
    output logic               is_throttling,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [TEMP_W-1:0] s1_temp_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;

    logic advance;
    logic step;
    logic in_xfer;

    tft_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tft_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .temperature (s1_temp_reg),
        .now_us      (s1_now_reg),
        .cfg         (cfg),
        .res         (res)
    );

    // result register free, or emptied by a transfer this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = in_xfer ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_temp_reg <= temperature;
            s1_now_reg  <= now_us;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cap_freq      = out_res_reg.cap;
    assign cap_changed   = out_res_reg.changed;
    assign is_throttling = out_res_reg.throttling;
    assign cfg_ready     = 1'b1;

endmodule
